FILE: sv/bpc_pkg.sv
package bpc_pkg;

  // Field widths fixed by the stream format
  localparam int FACES_W  = 11;
  localparam int SUM_W    = 11;
  localparam int WAYS_W   = 64;
  localparam int IN_TW    = 24;  // faces + target_sum, padded to whole bytes
  localparam int OUT_TW   = 72;  // ways + overflow, padded to whole bytes

  // One partition count, saturating at all ones
  typedef logic [WAYS_W-1:0] count_t;

endpackage

FILE: sv/bpc_sat_add.sv
module bpc_sat_add (
  input  bpc_pkg::count_t a,
  input  bpc_pkg::count_t b,
  output bpc_pkg::count_t sum,
  output logic            ovf
);
  import bpc_pkg::*;

  logic [WAYS_W:0] full;

  // Add with a carry bit, clamp to all ones when it carries out
  assign full = {1'b0, a} + {1'b0, b};
  assign ovf  = full[WAYS_W];
  assign sum  = ovf ? {WAYS_W{1'b1}} : full[WAYS_W-1:0];

endmodule

FILE: sv/bounded_partition_counter_unit.sv
// Bounded partition counter. Each input beat carries a largest part (faces) and a
// target sum; the single result beat carries the number of ways to write the sum
// as an unordered sum of parts 1..faces, saturated at 2^64-1, with an overflow
// flag set if any addition saturated. A target above MAX_SUM is clamped to
// MAX_SUM. One saturating adder works through a table memory of MAX_SUM+1
// entries, one update per cycle within the fill and each adder pass. With s the
// clamped sum and t = min(faces, s), a query with faces >= 1 first fills entries
// 0..s with one, then makes an adder pass over entries p..s for each part size
// p from 2 to t, then reads out entry s and delivers it. With faces = 0 the
// table is skipped. The input is not ready while a query is in progress; a
// finished result waits in the output register while the next query is taken,
// and the following result holds until that beat has gone.
module bounded_partition_counter_unit #(
  parameter int MAX_SUM = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // in_tdata: faces [10:0], target_sum [21:11], zero [23:22]
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [bpc_pkg::IN_TW-1:0]   in_tdata,
  // out_tdata: ways [63:0], overflow [64], zero [71:65]
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [bpc_pkg::OUT_TW-1:0]  out_tdata
);
  import bpc_pkg::*;

  localparam int DEPTH = MAX_SUM + 1;
  localparam int SW    = $clog2(DEPTH);
  localparam logic [SW-1:0] TWO = SW'(2);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FILL = 3'd1;
  localparam logic [2:0] S_RUN  = 3'd2;
  localparam logic [2:0] S_GAP  = 3'd3;
  localparam logic [2:0] S_READ = 3'd4;
  localparam logic [2:0] S_WAIT = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0]    state_r, state_nxt;
  logic [SW-1:0] sum_r, top_r, j_r, p_r;
  logic [SW-1:0] sum_nxt, top_nxt, j_nxt, p_nxt;
  logic          ovf_r, ovf_nxt;
  count_t        res_ways_r, res_ways_nxt;
  logic          pipe_v_r;
  logic [SW-1:0] pipe_j_r;
  count_t        rd_a_r, rd_b_r;
  logic          out_valid_r;
  count_t        out_ways_r;
  logic          out_ovf_r;

  count_t        ways_table [DEPTH];

  logic          in_fire, out_free;
  logic [31:0]   in_faces_ext, in_sum_ext;
  logic [SW-1:0] in_sum_cl, in_top;
  logic [SW-1:0] addr_a, addr_b, waddr;
  logic          wen;
  count_t        wdata, add_sum;
  logic          add_ovf;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // Clamp the target and work out the largest useful part
  assign in_faces_ext = 32'(in_tdata[FACES_W-1:0]);
  assign in_sum_ext   = 32'(in_tdata[FACES_W+SUM_W-1:FACES_W]);
  assign in_sum_cl    = (in_sum_ext > 32'(MAX_SUM)) ? SW'(MAX_SUM) : SW'(in_sum_ext);
  assign in_top       = (in_faces_ext < 32'(in_sum_cl)) ? SW'(in_faces_ext) : in_sum_cl;

  // Shared saturating adder: entry j plus entry j-p
  bpc_sat_add u_add (
    .a   (rd_a_r),
    .b   (rd_b_r),
    .sum (add_sum),
    .ovf (add_ovf)
  );

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    sum_nxt      = sum_r;
    top_nxt      = top_r;
    j_nxt        = j_r;
    p_nxt        = p_r;
    ovf_nxt      = ovf_r || (pipe_v_r && add_ovf);
    res_ways_nxt = res_ways_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          sum_nxt = in_sum_cl;
          top_nxt = in_top;
          j_nxt   = '0;
          ovf_nxt = 1'b0;
          if (in_faces_ext == 32'd0) begin
            res_ways_nxt = (in_sum_cl == '0) ? count_t'(1) : '0;
            state_nxt    = S_OUT;
          end else begin
            state_nxt = S_FILL;
          end
        end
      end
      S_FILL: begin
        if (j_r == sum_r) begin
          if (32'(top_r) < 32'd2) begin
            state_nxt = S_READ;
          end else begin
            p_nxt     = TWO;
            j_nxt     = TWO;
            state_nxt = S_RUN;
          end
        end else begin
          j_nxt = j_r + SW'(1);
        end
      end
      S_RUN: begin
        if (j_r == sum_r) begin
          state_nxt = S_GAP;
        end else begin
          j_nxt = j_r + SW'(1);
        end
      end
      S_GAP: begin
        // let the last write of this pass land before the next pass reads
        if (p_r == top_r) begin
          state_nxt = S_READ;
        end else begin
          p_nxt     = p_r + SW'(1);
          j_nxt     = p_r + SW'(1);
          state_nxt = S_RUN;
        end
      end
      S_READ: begin
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        res_ways_nxt = rd_a_r;
        state_nxt    = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      pipe_v_r <= 1'b0;
      ovf_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      pipe_v_r <= (state_r == S_RUN);
      ovf_r    <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sum_r      <= sum_nxt;
    top_r      <= top_nxt;
    j_r        <= j_nxt;
    p_r        <= p_nxt;
    res_ways_r <= res_ways_nxt;
    pipe_j_r   <= j_r;
  end

  // Table memory: one write port, two registered read ports
  assign addr_a = (state_r == S_RUN) ? j_r : sum_r;
  assign addr_b = j_r - p_r;
  assign wen    = (state_r == S_FILL) || pipe_v_r;
  assign waddr  = (state_r == S_FILL) ? j_r : pipe_j_r;
  assign wdata  = (state_r == S_FILL) ? count_t'(1) : add_sum;

  always_ff @(posedge clk) begin
    if (wen) begin
      ways_table[waddr] <= wdata;
    end
    rd_a_r <= ways_table[addr_a];
    rd_b_r <= ways_table[addr_b];
  end

  // Output register: hold the beat until it is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT && out_free) begin
      out_ways_r <= res_ways_r;
      out_ovf_r  <= ovf_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TW-WAYS_W-1){1'b0}}, out_ovf_r, out_ways_r};

  // Checks
  a_pipe_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
    pipe_v_r |-> (state_r == S_RUN || state_r == S_GAP))
    else $error("table update outside an adder pass");

  a_accept_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> !pipe_v_r)
    else $error("query accepted while an update is in flight");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FILL) |-> (j_r <= sum_r))
    else $error("fill index beyond target");

  a_part_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> (32'(p_r) >= 32'd2 && p_r <= top_r && j_r >= p_r))
    else $error("part size or index out of range in a pass");

endmodule
